### sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared sizes, opcodes, error codes and divider handshake types for the
// stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VAR_COUNT   = 256;
  localparam int DATA_WIDTH  = 32;

  localparam int OP_W   = 5;
  localparam int IDX_W  = 8;
  localparam int IO_W   = 32;
  localparam int ERR_W  = 2;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int VAR_AW = $clog2(VAR_COUNT);
  localparam int DIV_CW = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OPC_PUSHV = 5'd0,
    OPC_PUSHI = 5'd1,
    OPC_STO   = 5'd2,
    OPC_STP   = 5'd3,
    OPC_ADD   = 5'd4,
    OPC_SUB   = 5'd5,
    OPC_MUL   = 5'd6,
    OPC_DIV   = 5'd7,
    OPC_EQ    = 5'd11,
    OPC_NE    = 5'd12,
    OPC_LT    = 5'd13,
    OPC_GT    = 5'd14,
    OPC_LE    = 5'd15,
    OPC_GE    = 5'd16,
    OPC_AND   = 5'd17,
    OPC_OR    = 5'd18,
    OPC_NOT   = 5'd19,
    OPC_IN    = 5'd20,
    OPC_OUT   = 5'd21,
    OPC_STOP  = 5'd22
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

### sv/smx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_in_if
// Instruction channel: one instruction per beat.
// ----------------------------------------------------------------------------
interface smx_in_if;
  import smx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [IDX_W-1:0]       var_index;
  logic signed [IO_W-1:0] immediate;
  logic signed [IO_W-1:0] in_value;

  modport source (output valid, op, var_index, immediate, in_value, input ready);
  modport sink   (input valid, op, var_index, immediate, in_value, output ready);
endinterface

### sv/smx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_out_if
// Result channel: one status beat per executed instruction.
// ----------------------------------------------------------------------------
interface smx_out_if;
  import smx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   out_valid;
  logic signed [IO_W-1:0] out_value;
  logic [ERR_W-1:0]       error_code;
  logic                   halted;

  modport source (output valid, out_valid, out_value, error_code, halted, input ready);
  modport sink   (input valid, out_valid, out_value, error_code, halted, output ready);
endinterface

### sv/stack_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor
// Stack machine: operand stack and variable store in synchronous memories,
// top of stack held in a register, one instruction per input beat.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_ch     in   op, var_index, immediate, in_value
//  out_ch    out  out_valid, out_value, error_code, halted (one per instruction)
//
//  An instruction is accepted with its memory reads, then executed and written
//  back in S_EXEC. Divide waits in S_DIV for the bit-serial divider.
//  After reset a clearing pass zeroes the variable store with in_ch.ready low.
//  A waiting result sits in the output register; the next instruction is
//  accepted meanwhile and executes once that beat is taken.
// ----------------------------------------------------------------------------
module stack_machine_executor (
  input logic       clk,
  input logic       rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);
  import smx_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV} state_t;

  state_t            state_r, state_nxt;
  logic [VAR_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              halt_r, halt_nxt;
  word_t             tos_r, tos_nxt;

  // latched instruction
  logic [OP_W-1:0]        op_r;
  logic [VAR_AW-1:0]      idx_r;
  logic signed [IO_W-1:0] imm_r, inv_r;

  // output register
  logic                   out_full_r, out_full_nxt;
  logic                   ov_r, ov_nxt;
  logic signed [IO_W-1:0] oval_r, oval_nxt;
  err_t                   oerr_r, oerr_nxt;
  logic                   ohalt_r, ohalt_nxt;

  // memories
  word_t             stk_mem [STACK_DEPTH];
  word_t             var_mem [VAR_COUNT];
  word_t             nos_r;
  word_t             var_rd_r;
  logic              stk_we;
  logic [STK_AW-1:0] stk_wa;
  logic              var_we;
  logic [VAR_AW-1:0] var_wa;
  word_t             var_wd;

  logic            acc;
  logic            out_free;
  logic            out_load;
  logic [SP_W-1:0] sp_m1, sp_m2;
  logic            empty, short, full;
  logic            binary;
  word_t           r;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign acc      = in_ch.valid && in_ch.ready;
  assign out_free = !out_full_r || out_ch.ready;
  assign sp_m1    = sp_r - SP_W'(1);
  assign sp_m2    = sp_r - SP_W'(2);
  assign empty    = (sp_r == '0);
  assign short    = (sp_r < SP_W'(2));
  assign full     = (sp_r >= SP_W'(STACK_DEPTH));

  smx_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    binary = 1'b0;
    r      = '0;
    case (opcode_t'(op_r))
      OPC_ADD: begin binary = 1'b1; r = tos_r + nos_r; end
      OPC_SUB: begin binary = 1'b1; r = tos_r - nos_r; end
      OPC_MUL: begin binary = 1'b1; r = word_t'(tos_r * nos_r); end
      OPC_DIV: binary = 1'b1;
      OPC_EQ:  begin binary = 1'b1; r = word_t'(tos_r == nos_r); end
      OPC_NE:  begin binary = 1'b1; r = word_t'(tos_r != nos_r); end
      OPC_LT:  begin binary = 1'b1; r = word_t'($signed(tos_r) < $signed(nos_r)); end
      OPC_GT:  begin binary = 1'b1; r = word_t'($signed(tos_r) > $signed(nos_r)); end
      OPC_LE:  begin binary = 1'b1; r = word_t'($signed(tos_r) <= $signed(nos_r)); end
      OPC_GE:  begin binary = 1'b1; r = word_t'($signed(tos_r) >= $signed(nos_r)); end
      OPC_AND: begin binary = 1'b1; r = word_t'(tos_r != '0 && nos_r != '0); end
      OPC_OR:  begin binary = 1'b1; r = word_t'(tos_r != '0 || nos_r != '0); end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    sp_nxt        = sp_r;
    halt_nxt      = halt_r;
    tos_nxt       = tos_r;
    out_full_nxt  = out_full_r && !out_ch.ready;
    ov_nxt        = 1'b0;
    oval_nxt      = '0;
    oerr_nxt      = ERR_OK;
    ohalt_nxt     = halt_r;
    out_load      = 1'b0;
    stk_we        = 1'b0;
    stk_wa        = sp_m1[STK_AW-1:0];
    var_we        = 1'b0;
    var_wa        = idx_r;
    var_wd        = tos_r;
    div_req.start    = 1'b0;
    div_req.dividend = tos_r;
    div_req.divisor  = nos_r;

    case (state_r)
      S_CLEAR: begin
        var_we      = 1'b1;
        var_wa      = clr_cnt_r;
        var_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + VAR_AW'(1);
        if (clr_cnt_r == VAR_AW'(VAR_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (!halt_r) begin
            case (opcode_t'(op_r))
              OPC_PUSHV, OPC_PUSHI: begin
                if (full) begin
                  oerr_nxt = ERR_OVER;
                end else begin
                  // spill the old top below the new one
                  stk_we  = !empty;
                  tos_nxt = (opcode_t'(op_r) == OPC_PUSHV) ? var_rd_r : DATA_WIDTH'(imm_r);
                  sp_nxt  = sp_r + SP_W'(1);
                end
              end
              OPC_STO, OPC_STP: begin
                if (empty) begin
                  oerr_nxt = ERR_UNDER;
                end else begin
                  var_we = 1'b1;
                  if (opcode_t'(op_r) == OPC_STP) begin
                    tos_nxt = nos_r;
                    sp_nxt  = sp_m1;
                  end
                end
              end
              OPC_NOT: begin
                if (empty) oerr_nxt = ERR_UNDER;
                else tos_nxt = word_t'(tos_r == '0);
              end
              OPC_IN: begin
                var_we = 1'b1;
                var_wd = DATA_WIDTH'(inv_r);
              end
              OPC_OUT: begin
                if (empty) begin
                  oerr_nxt = ERR_UNDER;
                end else begin
                  ov_nxt   = 1'b1;
                  oval_nxt = IO_W'($signed(tos_r));
                  tos_nxt  = nos_r;
                  sp_nxt   = sp_m1;
                end
              end
              OPC_STOP: begin
                halt_nxt  = 1'b1;
                ohalt_nxt = 1'b1;
              end
              default: ;
            endcase
            if (binary) begin
              if (short) begin
                oerr_nxt = ERR_UNDER;
              end else if (opcode_t'(op_r) == OPC_DIV) begin
                if (nos_r == '0) begin
                  oerr_nxt = ERR_DIV0;
                end else begin
                  // result comes later from the divider
                  out_load      = 1'b0;
                  div_req.start = 1'b1;
                  state_nxt     = S_DIV;
                end
              end else begin
                tos_nxt = r;
                sp_nxt  = sp_m1;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quotient;
          sp_nxt    = sp_m1;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (out_load) out_full_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      sp_r       <= '0;
      halt_r     <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      sp_r       <= sp_nxt;
      halt_r     <= halt_nxt;
      out_full_r <= out_full_nxt;
    end
    tos_r <= tos_nxt;
    if (acc) begin
      op_r  <= in_ch.op;
      idx_r <= in_ch.var_index[VAR_AW-1:0];
      imm_r <= in_ch.immediate;
      inv_r <= in_ch.in_value;
    end
    if (out_load) begin
      ov_r    <= ov_nxt;
      oval_r  <= oval_nxt;
      oerr_r  <= oerr_nxt;
      ohalt_r <= ohalt_nxt;
    end
  end

  // operand stack: entries below the cached top, read at sp-2 on accept
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= tos_r;
    if (acc) nos_r <= stk_mem[sp_m2[STK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (var_we) var_mem[var_wa] <= var_wd;
    if (acc) var_rd_r <= var_mem[in_ch.var_index[VAR_AW-1:0]];
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_full_r;
  assign out_ch.out_valid  = ov_r;
  assign out_ch.out_value  = oval_r;
  assign out_ch.error_code = oerr_r;
  assign out_ch.halted     = ohalt_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r && $stable(sp_r))
    else $error("stack changed after stop");

  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (nos_r != '0) && !short)
    else $error("divider started without two operands or with zero divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_full_r && !out_ch.ready))
    else $error("result overwrote a pending beat");

endmodule

### sv/smx_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. The divisor is never zero when started.
// ----------------------------------------------------------------------------
module smx_div (
  input  logic             clk,
  input  logic             rst_n,
  input  smx_pkg::div_req_t req,
  output smx_pkg::div_rsp_t rsp
);
  import smx_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  word_t             rem_r, rem_nxt;
  word_t             quo_r, quo_nxt;
  word_t             dvs_r, dvs_nxt;
  logic [DATA_WIDTH:0] rem_sh;

  function automatic word_t mag(input word_t v);
    mag = v[DATA_WIDTH-1] ? word_t'(-v) : v;
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[DATA_WIDTH-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[DATA_WIDTH-1] ^ req.divisor[DATA_WIDTH-1];
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = mag(req.dividend);
      dvs_nxt  = mag(req.divisor);
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = word_t'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DATA_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? word_t'(-quo_r) : quo_r;

endmodule
